### rtl/core/sbx_pkg.sv
// ----------------------------------------------------------------------------
// sbx_pkg: shared constants and types for the SBX crossover unit
// Fixed-point formats, register reset values, register indexes and the
// constant root table of the pipelined power-of-two unit.
// ----------------------------------------------------------------------------
package sbx_pkg;

  // Default gene and draw widths
  localparam int unsigned DEF_GENE_WIDTH = 32;
  localparam int unsigned DEF_DRAW_WIDTH = 16;

  // Fixed-point formats
  localparam int unsigned LOG_FRAC  = 26;  // fraction bits of log2 and exponent
  localparam int unsigned Q_FRAC    = 30;  // mantissa fraction bits (Q1.30)
  localparam int unsigned MANT_W    = 31;  // Q1.30 mantissa width
  localparam int unsigned B_FRAC    = 24;  // fraction bits of spread factor
  localparam int unsigned P_LIM_LOG = 40;  // product magnitude limit, log2

  // Configuration registers
  localparam int unsigned PROB_W     = 17;
  localparam int unsigned NC_W       = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam logic [PROB_W-1:0] PROB_RESET = 17'd58982;
  localparam logic [NC_W-1:0]   NC_RESET   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PROB = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NC   = 1'b1;

  typedef logic [MANT_W-1:0] root_tab_t [LOG_FRAC];

  function automatic int unsigned max_u(int unsigned x, int unsigned y);
    return (x > y) ? x : y;
  endfunction

  // Floor square root, evaluated at elaboration only
  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] bit_m;
    x = v;
    r = '0;
    bit_m = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bit_m > x) bit_m = bit_m >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bit_m != 64'd0) begin
        if (x >= r + bit_m) begin
          x = x - (r + bit_m);
          r = (r >> 1) + bit_m;
        end else begin
          r = r >> 1;
        end
        bit_m = bit_m >> 2;
      end
    end
    return r;
  endfunction

  // Factors 2^(2^-k) in Q1.30, k = 1 .. LOG_FRAC, each a root of the one before
  function automatic root_tab_t exp_root_table();
    root_tab_t   tab;
    logic [63:0] r;
    r = isqrt64(64'd1 << 61);
    for (int k = 0; k < int'(LOG_FRAC); k++) begin
      tab[k] = r[MANT_W-1:0];
      r = isqrt64(r << Q_FRAC);
    end
    return tab;
  endfunction

  localparam root_tab_t EXP_ROOTS = exp_root_table();

endpackage

### rtl/core/sbx_log2.sv
// ----------------------------------------------------------------------------
// sbx_log2: pipelined fixed-point base-2 logarithm
// One normalize stage, then one squaring stage per fraction bit.
// ----------------------------------------------------------------------------
module sbx_log2 #(
  parameter int unsigned DRAW_WIDTH = 16,
  parameter int unsigned SIDE_W     = 69
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              en_i,
  input  logic                                              valid_i,
  input  logic [DRAW_WIDTH-1:0]                             n_i,
  input  logic [SIDE_W-1:0]                                 side_i,
  output logic                                              valid_o,
  output logic [$clog2(DRAW_WIDTH)+sbx_pkg::LOG_FRAC-1:0]  log_o,
  output logic [SIDE_W-1:0]                                 side_o
);
  import sbx_pkg::*;

  localparam int unsigned EW    = $clog2(DRAW_WIDTH);
  localparam int unsigned DEPTH = LOG_FRAC + 1;

  logic [EW-1:0]         e_d;
  logic [DRAW_WIDTH-1:0] norm;
  logic [63:0]           wide;
  logic [2*MANT_W-1:0]   sq;
  logic [MANT_W:0]       sh;

  logic [MANT_W-1:0]   m_d [DEPTH];
  logic [MANT_W-1:0]   m_q [DEPTH];
  logic [LOG_FRAC-1:0] f_d [DEPTH];
  logic [LOG_FRAC-1:0] f_q [DEPTH];
  logic [EW-1:0]       e_q [DEPTH];
  logic [SIDE_W-1:0]   side_q [DEPTH];
  logic [DEPTH-1:0]    v_q;

  // Normalize, then square once per fraction bit
  always_comb begin
    e_d = '0;
    for (int i = 0; i < int'(DRAW_WIDTH); i++) begin
      if (n_i[i]) e_d = EW'(i);
    end
    norm = n_i << (EW'(DRAW_WIDTH - 1) - e_d);
    wide = {norm, {(64-DRAW_WIDTH){1'b0}}};
    m_d[0] = wide[63:64-MANT_W];
    f_d[0] = '0;
    sq = '0;
    sh = '0;
    for (int k = 1; k < int'(DEPTH); k++) begin
      sq = m_q[k-1] * m_q[k-1];
      sh = sq[2*MANT_W-1:Q_FRAC];
      f_d[k] = f_q[k-1];
      if (sh[MANT_W]) begin
        m_d[k] = sh[MANT_W:1];
        f_d[k][LOG_FRAC-k] = 1'b1;
      end else begin
        m_d[k] = sh[MANT_W-1:0];
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[DEPTH-2:0], valid_i};
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q       <= m_d;
      f_q       <= f_d;
      e_q[0]    <= e_d;
      side_q[0] <= side_i;
      for (int k = 1; k < int'(DEPTH); k++) begin
        e_q[k]    <= e_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign valid_o = v_q[DEPTH-1];
  assign log_o   = {e_q[DEPTH-1], f_q[DEPTH-1]};
  assign side_o  = side_q[DEPTH-1];

endmodule

### rtl/core/sbx_div.sv
// ----------------------------------------------------------------------------
// sbx_div: pipelined exponent divider
// Forms (DRAW_WIDTH-1) - log2 and divides it by nc+1, one quotient bit a stage.
// ----------------------------------------------------------------------------
module sbx_div #(
  parameter int unsigned DRAW_WIDTH = 16,
  parameter int unsigned SIDE_W     = 69
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              en_i,
  input  logic                                              valid_i,
  input  logic [$clog2(DRAW_WIDTH)+sbx_pkg::LOG_FRAC-1:0]  log_i,
  input  logic [sbx_pkg::NC_W-1:0]                          nc_i,
  input  logic [SIDE_W-1:0]                                 side_i,
  output logic                                              valid_o,
  output logic [$clog2(DRAW_WIDTH)+sbx_pkg::LOG_FRAC-1:0]  quot_o,
  output logic [SIDE_W-1:0]                                 side_o
);
  import sbx_pkg::*;

  localparam int unsigned NW    = $clog2(DRAW_WIDTH) + LOG_FRAC;
  localparam int unsigned DVW   = NC_W + 1;
  localparam int unsigned DEPTH = NW + 1;
  localparam logic [NW-1:0] TOP = NW'(DRAW_WIDTH - 1) << LOG_FRAC;

  logic [DVW-1:0] dv;
  logic [DVW:0]   cand;

  logic [NW-1:0]     x_d [DEPTH];
  logic [NW-1:0]     x_q [DEPTH];
  logic [DVW-1:0]    r_d [DEPTH];
  logic [DVW-1:0]    r_q [DEPTH];
  logic [SIDE_W-1:0] side_q [DEPTH];
  logic [DEPTH-1:0]  v_q;

  // Restoring division, shift quotient bits in as numerator bits leave
  always_comb begin
    dv = DVW'(nc_i) + DVW'(1);
    x_d[0] = TOP - log_i;
    r_d[0] = '0;
    cand = '0;
    for (int k = 1; k < int'(DEPTH); k++) begin
      cand = {r_q[k-1], x_q[k-1][NW-1]};
      if (cand >= {1'b0, dv}) begin
        r_d[k] = DVW'(cand - {1'b0, dv});
        x_d[k] = {x_q[k-1][NW-2:0], 1'b1};
      end else begin
        r_d[k] = cand[DVW-1:0];
        x_d[k] = {x_q[k-1][NW-2:0], 1'b0};
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[DEPTH-2:0], valid_i};
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q       <= x_d;
      r_q       <= r_d;
      side_q[0] <= side_i;
      for (int k = 1; k < int'(DEPTH); k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign valid_o = v_q[DEPTH-1];
  assign quot_o  = x_q[DEPTH-1];
  assign side_o  = side_q[DEPTH-1];

endmodule

### rtl/core/sbx_exp2.sv
// ----------------------------------------------------------------------------
// sbx_exp2: pipelined power of two of the exponent fraction
// Multiplies in one constant root factor per set fraction bit, one stage each.
// ----------------------------------------------------------------------------
module sbx_exp2 #(
  parameter int unsigned DRAW_WIDTH = 16,
  parameter int unsigned SIDE_W     = 69
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              en_i,
  input  logic                                              valid_i,
  input  logic [$clog2(DRAW_WIDTH)+sbx_pkg::LOG_FRAC-1:0]  t_i,
  input  logic [SIDE_W-1:0]                                 side_i,
  output logic                                              valid_o,
  output logic [sbx_pkg::MANT_W-1:0]                        g_o,
  output logic [$clog2(DRAW_WIDTH)-1:0]                     ip_o,
  output logic [SIDE_W-1:0]                                 side_o
);
  import sbx_pkg::*;

  localparam int unsigned IPW   = $clog2(DRAW_WIDTH);
  localparam int unsigned DEPTH = LOG_FRAC + 1;
  localparam logic [MANT_W-1:0] Q30_ONE = MANT_W'(1) << Q_FRAC;

  logic [2*MANT_W-1:0] pr;

  logic [MANT_W-1:0]   g_d [DEPTH];
  logic [MANT_W-1:0]   g_q [DEPTH];
  logic [LOG_FRAC-1:0] fp_q [DEPTH];
  logic [IPW-1:0]      ip_q [DEPTH];
  logic [SIDE_W-1:0]   side_q [DEPTH];
  logic [DEPTH-1:0]    v_q;

  // Multiply in the root factor of each set fraction bit
  always_comb begin
    g_d[0] = Q30_ONE;
    pr = '0;
    for (int k = 1; k < int'(DEPTH); k++) begin
      pr = g_q[k-1] * EXP_ROOTS[k-1];
      if (fp_q[k-1][LOG_FRAC-k]) begin
        g_d[k] = pr[Q_FRAC+MANT_W-1:Q_FRAC];
      end else begin
        g_d[k] = g_q[k-1];
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[DEPTH-2:0], valid_i};
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g_q       <= g_d;
      fp_q[0]   <= t_i[LOG_FRAC-1:0];
      ip_q[0]   <= t_i[IPW+LOG_FRAC-1:LOG_FRAC];
      side_q[0] <= side_i;
      for (int k = 1; k < int'(DEPTH); k++) begin
        fp_q[k]   <= fp_q[k-1];
        ip_q[k]   <= ip_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign valid_o = v_q[DEPTH-1];
  assign g_o     = g_q[DEPTH-1];
  assign ip_o    = ip_q[DEPTH-1];
  assign side_o  = side_q[DEPTH-1];

endmodule

### rtl/core/sbx_combine.sv
// ----------------------------------------------------------------------------
// sbx_combine: child gene arithmetic
// Scales the spread factor, multiplies it by the parent distance in two
// partial products, and forms the saturated children. Last stage is the
// output register.
// ----------------------------------------------------------------------------
module sbx_combine #(
  parameter int unsigned GENE_WIDTH = 32,
  parameter int unsigned DRAW_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [sbx_pkg::MANT_W-1:0]        g_i,
  input  logic [$clog2(DRAW_WIDTH)-1:0]     ip_i,
  input  logic                              small_i,
  input  logic                              zero_i,
  input  logic                              cross_i,
  input  logic [GENE_WIDTH-1:0]             gene_a_i,
  input  logic [GENE_WIDTH-1:0]             gene_b_i,
  input  logic                              last_gene_i,
  input  logic                              last_pair_i,
  output logic                              valid_o,
  output logic [GENE_WIDTH-1:0]             child_a_o,
  output logic [GENE_WIDTH-1:0]             child_b_o,
  output logic                              end_of_individual_o,
  output logic                              end_of_batch_o,
  output logic                              saturated_o
);
  import sbx_pkg::*;

  localparam int unsigned GW  = GENE_WIDTH;
  localparam int unsigned IPW = $clog2(DRAW_WIDTH);
  localparam int unsigned BW  = DRAW_WIDTH + B_FRAC;
  localparam int unsigned BL  = BW / 2;
  localparam int unsigned BH  = BW - BL;
  localparam int unsigned PFW = BW + GW + 1;
  localparam int unsigned PW  = PFW - B_FRAC;
  localparam int unsigned CPW = P_LIM_LOG + 1;
  localparam int unsigned WW  = max_u(PW, CPW) + 1;
  localparam int unsigned XW  = max_u(GW + 1, CPW + 1) + 1;
  localparam logic [WW-1:0] P_LIM = WW'(1) << P_LIM_LOG;

  // Stage 1: spread factor, distance, sum
  logic [GW:0]     diff;
  logic            neg_d;
  logic [GW:0]     ad_d;
  logic [GW:0]     s_d;
  logic [IPW+2:0]  shv;
  logic [BW+5:0]   lw;
  logic [BW-1:0]   b_d;

  logic            v1_q, cross1_q, lg1_q, lp1_q, neg1_q;
  logic [BW-1:0]   b1_q;
  logic [GW:0]     ad1_q, s1_q;
  logic [GW-1:0]   a1_q, c1_q;

  always_comb begin
    diff  = {gene_a_i[GW-1], gene_a_i} - {gene_b_i[GW-1], gene_b_i};
    neg_d = diff[GW];
    ad_d  = neg_d ? (GW+1)'(-diff) : diff;
    s_d   = {gene_a_i[GW-1], gene_a_i} + {gene_b_i[GW-1], gene_b_i};
    shv   = (IPW+3)'(ip_i) + (IPW+3)'(6);
    lw    = (BW+6)'(g_i) << ip_i;
    if (zero_i) begin
      b_d = '0;
    end else if (small_i) begin
      b_d = BW'(g_i) >> shv;
    end else begin
      b_d = lw[BW+5:6];
    end
  end

  // Stage 2: partial products
  logic            v2_q, cross2_q, lg2_q, lp2_q, neg2_q;
  logic [BL+GW:0]  pl2_q;
  logic [BH+GW:0]  ph2_q;
  logic [GW:0]     s2_q;
  logic [GW-1:0]   a2_q, c2_q;

  // Stage 3: product, truncated and limited
  logic [PFW-1:0]  pf;
  logic [WW-1:0]   pw;
  logic [CPW-1:0]  pc_d;

  logic            v3_q, cross3_q, lg3_q, lp3_q, neg3_q;
  logic [CPW-1:0]  pc3_q;
  logic [GW:0]     s3_q;
  logic [GW-1:0]   a3_q, c3_q;

  always_comb begin
    pf = (PFW'(ph2_q) << BL) + PFW'(pl2_q);
    pw = WW'(pf[PFW-1:B_FRAC]);
    pc_d = (pw > P_LIM) ? CPW'(P_LIM) : CPW'(pw);
  end

  // Stage 4: children, halved and saturated
  logic [XW-1:0]   sx, sp, xa, xb, ha, hb;
  logic            ova, una, ovb, unb;
  logic [GW-1:0]   ca_d, cb_d;
  logic            clip_d;

  localparam logic [GW-1:0] G_MAX = {1'b0, {(GW-1){1'b1}}};
  localparam logic [GW-1:0] G_MIN = {1'b1, {(GW-1){1'b0}}};

  always_comb begin
    sx  = {{(XW-GW-1){s3_q[GW]}}, s3_q};
    sp  = neg3_q ? XW'(-XW'(pc3_q)) : XW'(pc3_q);
    xa  = sx + sp;
    xb  = sx - sp;
    ha  = {xa[XW-1], xa[XW-1:1]};
    hb  = {xb[XW-1], xb[XW-1:1]};
    ova = !ha[XW-1] && (ha[XW-2:GW-1] != '0);
    una =  ha[XW-1] && (ha[XW-2:GW-1] != '1);
    ovb = !hb[XW-1] && (hb[XW-2:GW-1] != '0);
    unb =  hb[XW-1] && (hb[XW-2:GW-1] != '1);
    if (!cross3_q) begin
      ca_d   = a3_q;
      cb_d   = c3_q;
      clip_d = 1'b0;
    end else begin
      ca_d   = ova ? G_MAX : (una ? G_MIN : ha[GW-1:0]);
      cb_d   = ovb ? G_MAX : (unb ? G_MIN : hb[GW-1:0]);
      clip_d = ova | una | ovb | unb;
    end
  end

  logic v4_q;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b1_q     <= b_d;
      ad1_q    <= ad_d;
      s1_q     <= s_d;
      neg1_q   <= neg_d;
      a1_q     <= gene_a_i;
      c1_q     <= gene_b_i;
      cross1_q <= cross_i;
      lg1_q    <= last_gene_i;
      lp1_q    <= last_pair_i;

      pl2_q    <= b1_q[BL-1:0] * ad1_q;
      ph2_q    <= b1_q[BW-1:BL] * ad1_q;
      s2_q     <= s1_q;
      neg2_q   <= neg1_q;
      a2_q     <= a1_q;
      c2_q     <= c1_q;
      cross2_q <= cross1_q;
      lg2_q    <= lg1_q;
      lp2_q    <= lp1_q;

      pc3_q    <= pc_d;
      s3_q     <= s2_q;
      neg3_q   <= neg2_q;
      a3_q     <= a2_q;
      c3_q     <= c2_q;
      cross3_q <= cross2_q;
      lg3_q    <= lg2_q;
      lp3_q    <= lp2_q;

      child_a_o           <= ca_d;
      child_b_o           <= cb_d;
      saturated_o         <= clip_d;
      end_of_individual_o <= lg3_q;
      end_of_batch_o      <= lp3_q;
    end
  end

  assign valid_o = v4_q;

endmodule

### rtl/core/simulated_binary_crossover_unit.sv
// ----------------------------------------------------------------------------
// simulated_binary_crossover_unit: SBX crossover, one gene pair per cycle unless stalled
// Streams parent gene pairs in and child gene pairs out, with saturation.
// ----------------------------------------------------------------------------
// The unit takes one gene position of a parent pair per clock while the output
// is not stalled, and returns the two child genes of that position, in order.
// The pipeline runs through the log2 squaring chain (one stage per fraction
// bit), the exponent divider (one quotient bit per stage), the power-of-two
// root multiplier chain and the four stages of the child arithmetic. One
// transaction enters every cycle; when the output is stalled the pipeline
// holds and one further input transaction is parked in a skid register.
// Write the configuration registers only while no transaction is in flight.
// The pair draw must be the same on every gene of a pair.
module simulated_binary_crossover_unit #(
  parameter int unsigned GENE_WIDTH = sbx_pkg::DEF_GENE_WIDTH,
  parameter int unsigned DRAW_WIDTH = sbx_pkg::DEF_DRAW_WIDTH
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  // Input stream
  input  logic                                      s_axis_tvalid_i,
  output logic                                      s_axis_tready_o,
  // gene_a, gene_b, pair_draw, gene_draw (lowest first), zero padded
  input  logic [((2*GENE_WIDTH+2*DRAW_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  input  logic                                      s_axis_tlast_i,  // last_gene
  input  logic                                      s_axis_tuser_i,  // last_pair
  // Output stream
  output logic                                      m_axis_tvalid_o,
  input  logic                                      m_axis_tready_i,
  // child_a, child_b (lowest first), zero padded
  output logic [((2*GENE_WIDTH+7)/8)*8-1:0]         m_axis_tdata_o,
  output logic                                      m_axis_tlast_o,  // end_of_individual
  output logic [1:0]                                m_axis_tuser_o,  // end_of_batch, saturated
  // Configuration write channel
  input  logic                                      cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  logic [sbx_pkg::CFG_IDX_W-1:0]             cfg_index_i,
  input  logic [sbx_pkg::PROB_W-1:0]                cfg_data_i
);
  import sbx_pkg::*;

  localparam int unsigned GW     = GENE_WIDTH;
  localparam int unsigned DW     = DRAW_WIDTH;
  localparam int unsigned OUT_W  = ((2*GW + 7) / 8) * 8;
  localparam int unsigned ITEM_W = 2*GW + 2*DW;
  localparam int unsigned SIDE_W = 2*GW + 5;
  localparam int unsigned NW     = $clog2(DW) + LOG_FRAC;
  localparam int unsigned IPW    = $clog2(DW);
  localparam int unsigned CMPW   = max_u(DW, PROB_W);
  localparam logic [DW:0] HALF   = (DW+1)'(1) << (DW - 1);
  localparam logic [DW:0] FULL   = (DW+1)'(1) << DW;

  // Configuration registers
  logic [PROB_W-1:0] prob_q;
  logic [NC_W-1:0]   nc_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prob_q <= PROB_RESET;
      nc_q   <= NC_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PROB: prob_q <= cfg_data_i;
        REG_NC:   nc_q   <= cfg_data_i[NC_W-1:0];
        default:  ;
      endcase
    end
  end

  // Pipeline advances whenever the output register is free or drained
  logic en;
  logic out_valid;

  assign en = !out_valid || m_axis_tready_i;

  // Skid register: park one transaction while the pipeline holds
  logic              skid_v_q;
  logic [ITEM_W-1:0] skid_data_q;
  logic              skid_lg_q, skid_lp_q;

  logic              head_v;
  logic [ITEM_W-1:0] head_data;
  logic              head_lg, head_lp;

  assign s_axis_tready_o = !skid_v_q;
  assign head_v    = skid_v_q || s_axis_tvalid_i;
  assign head_data = skid_v_q ? skid_data_q : s_axis_tdata_i[ITEM_W-1:0];
  assign head_lg   = skid_v_q ? skid_lg_q : s_axis_tlast_i;
  assign head_lp   = skid_v_q ? skid_lp_q : s_axis_tuser_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (en) skid_v_q <= 1'b0;
    end else if (s_axis_tvalid_i && !en) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_v_q && !en) begin
      skid_data_q <= s_axis_tdata_i[ITEM_W-1:0];
      skid_lg_q   <= s_axis_tlast_i;
      skid_lp_q   <= s_axis_tuser_i;
    end
  end

  // Front stage: crossing decision and log2 operand
  logic [GW-1:0] h_a, h_c;
  logic [DW-1:0] h_pd, h_gd;
  logic          cross_d, zero_d, small_d;
  logic [DW-1:0] n_d;
  logic [DW:0]   n_wide;

  assign h_a  = head_data[GW-1:0];
  assign h_c  = head_data[2*GW-1:GW];
  assign h_pd = head_data[2*GW+DW-1:2*GW];
  assign h_gd = head_data[2*GW+2*DW-1:2*GW+DW];

  always_comb begin
    cross_d = CMPW'(h_pd) < CMPW'(prob_q);
    zero_d  = (h_gd == '0);
    small_d = ({1'b0, h_gd} <= HALF);
    n_wide  = small_d ? {1'b0, h_gd} : (FULL - {1'b0, h_gd});
    n_d     = zero_d ? DW'(1) : n_wide[DW-1:0];
  end

  logic              f_v_q;
  logic [DW-1:0]     f_n_q;
  logic [SIDE_W-1:0] f_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else if (en) begin
      f_v_q <= head_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_n_q    <= n_d;
      f_side_q <= {head_lp, head_lg, small_d, zero_d, cross_d, h_c, h_a};
    end
  end

  // Logarithm
  logic              l_v;
  logic [NW-1:0]     l_log;
  logic [SIDE_W-1:0] l_side;

  sbx_log2 #(
    .DRAW_WIDTH (DW),
    .SIDE_W     (SIDE_W)
  ) u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_v_q),
    .n_i     (f_n_q),
    .side_i  (f_side_q),
    .valid_o (l_v),
    .log_o   (l_log),
    .side_o  (l_side)
  );

  // Exponent division by nc+1
  logic              d_v;
  logic [NW-1:0]     d_t;
  logic [SIDE_W-1:0] d_side;

  sbx_div #(
    .DRAW_WIDTH (DW),
    .SIDE_W     (SIDE_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (l_v),
    .log_i   (l_log),
    .nc_i    (nc_q),
    .side_i  (l_side),
    .valid_o (d_v),
    .quot_o  (d_t),
    .side_o  (d_side)
  );

  // Power of two
  logic              x_v;
  logic [MANT_W-1:0] x_g;
  logic [IPW-1:0]    x_ip;
  logic [SIDE_W-1:0] x_side;

  sbx_exp2 #(
    .DRAW_WIDTH (DW),
    .SIDE_W     (SIDE_W)
  ) u_exp2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_v),
    .t_i     (d_t),
    .side_i  (d_side),
    .valid_o (x_v),
    .g_o     (x_g),
    .ip_o    (x_ip),
    .side_o  (x_side)
  );

  // Child arithmetic and output register
  logic [GW-1:0] child_a, child_b;
  logic          end_ind, end_batch, sat;

  sbx_combine #(
    .GENE_WIDTH (GW),
    .DRAW_WIDTH (DW)
  ) u_combine (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .en_i                (en),
    .valid_i             (x_v),
    .g_i                 (x_g),
    .ip_i                (x_ip),
    .small_i             (x_side[2*GW+2]),
    .zero_i              (x_side[2*GW+1]),
    .cross_i             (x_side[2*GW]),
    .gene_a_i            (x_side[GW-1:0]),
    .gene_b_i            (x_side[2*GW-1:GW]),
    .last_gene_i         (x_side[2*GW+3]),
    .last_pair_i         (x_side[2*GW+4]),
    .valid_o             (out_valid),
    .child_a_o           (child_a),
    .child_b_o           (child_b),
    .end_of_individual_o (end_ind),
    .end_of_batch_o      (end_batch),
    .saturated_o         (sat)
  );

  assign m_axis_tvalid_o = out_valid;
  assign m_axis_tdata_o  = OUT_W'({child_b, child_a});
  assign m_axis_tlast_o  = end_ind;
  assign m_axis_tuser_o  = {sat, end_batch};

endmodule

### tb/tb_simulated_binary_crossover_unit.sv
// ----------------------------------------------------------------------------
// tb_simulated_binary_crossover_unit: self-checking SBX crossover regression
// Streams parent gene pairs through the unit under several probability and
// distribution index settings. A bit-exact fixed-point predictor computes the
// expected child pair for each accepted input transaction, and a monitor
// compares each output transaction against the oldest expected one. Both
// stream sides idle at random, and the receiver holds off once for a long
// stretch to back up the pipeline.
// ----------------------------------------------------------------------------
module tb_simulated_binary_crossover_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sbx_pkg::*;

  localparam int unsigned GW        = 32;
  localparam int unsigned DW        = 16;
  localparam int unsigned LATENCY   = 90;
  localparam int unsigned DRAIN_CYC = 2 * LATENCY;
  localparam int unsigned IDLE_LIM  = 20000;
  localparam int unsigned HOLD_CYC  = 600;

  typedef struct {
    logic signed [GW-1:0] gene_a;
    logic signed [GW-1:0] gene_b;
    logic [DW-1:0]        pair_draw;
    logic [DW-1:0]        gene_draw;
    logic                 last_gene;
    logic                 last_pair;
  } parent_genes_t;

  typedef struct {
    logic signed [GW-1:0] child_a;
    logic signed [GW-1:0] child_b;
    logic                 end_of_individual;
    logic                 end_of_batch;
    logic                 saturated;
  } child_genes_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [95:0]         s_axis_tdata_i  = '0;
  logic                s_axis_tlast_i  = 1'b0;
  logic                s_axis_tuser_i  = 1'b0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [63:0]         m_axis_tdata_o;
  logic                m_axis_tlast_o;
  logic [1:0]          m_axis_tuser_o;
  logic                cfg_valid_i     = 1'b0;
  logic                cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i    = REG_PROB;
  logic [PROB_W-1:0]   cfg_data_i      = '0;

  simulated_binary_crossover_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // Predictor copy of the configuration
  logic [PROB_W-1:0] cross_prob = PROB_RESET;
  logic [NC_W-1:0]   dist_index = NC_RESET;

  longint unsigned pow2_roots [LOG_FRAC];

  parent_genes_t pending_genes [$];
  child_genes_t  expected_children [$];
  parent_genes_t cur_genes;

  int unsigned errors    = 0;
  int unsigned genes_in  = 0;
  int unsigned genes_out = 0;
  int unsigned sat_seen  = 0;
  int unsigned idle_cyc  = 0;

  // ---------------------------------------------------------------- predictor
  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // log2 with 26 fraction bits by repeated squaring of a Q1.30 mantissa
  function automatic longint unsigned log2_q26(longint unsigned n);
    int unsigned     e;
    longint unsigned m, res;
    e = 0;
    while (e < 63 && (n >> (e + 1)) != 0) e++;
    m = (e <= 30) ? (n << (30 - e)) : (n >> (e - 30));
    res = longint'(e) << LOG_FRAC;
    for (int k = 1; k <= LOG_FRAC; k++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        res = res | (64'd1 << (LOG_FRAC - k));
      end
    end
    return res;
  endfunction

  function automatic longint unsigned pow2_frac(longint unsigned fp);
    longint unsigned g;
    g = 64'd1 << 30;
    for (int k = 1; k <= LOG_FRAC; k++) begin
      if ((fp >> (LOG_FRAC - k)) & 1) g = (g * pow2_roots[k-1]) >> 30;
    end
    return g;
  endfunction

  // Spread factor with 24 fraction bits
  function automatic longint unsigned spread_q24(longint unsigned d, logic [NC_W-1:0] nc);
    longint unsigned top, t, ip, g;
    top = longint'(DW - 1) << LOG_FRAC;
    if (d == 0) return 0;
    if (d <= (64'd1 << (DW - 1))) begin
      t = (top - log2_q26(d)) / (longint'(nc) + 1);
      ip = t >> LOG_FRAC;
      g = pow2_frac(t & ((64'd1 << LOG_FRAC) - 1));
      return (6 + ip < 64) ? (g >> (6 + ip)) : 0;
    end
    t = (top - log2_q26((64'd1 << DW) - d)) / (longint'(nc) + 1);
    ip = t >> LOG_FRAC;
    g = pow2_frac(t & ((64'd1 << LOG_FRAC) - 1));
    return (g << ip) >> 6;
  endfunction

  function automatic child_genes_t cross_genes(parent_genes_t p);
    child_genes_t    c;
    longint          a, bb, s, diff, sp, ca, cb;
    longint unsigned sf, ad, prod;
    longint          hi, lo;
    hi = (64'sd1 <<< (GW - 1)) - 1;
    lo = -hi - 1;
    a  = p.gene_a;
    bb = p.gene_b;
    ca = a;
    cb = bb;
    c.saturated = 1'b0;
    if ({1'b0, p.pair_draw} < cross_prob) begin
      sf   = spread_q24(p.gene_draw, dist_index);
      s    = a + bb;
      diff = a - bb;
      ad   = (diff < 0) ? -diff : diff;
      prod = (sf >> 24) * ad + (((sf & 64'hFFFFFF) * ad) >> 24);
      if (prod > (64'd1 << 40)) prod = 64'd1 << 40;
      sp = (diff < 0) ? -longint'(prod) : longint'(prod);
      ca = (s + sp) >>> 1;
      cb = (s - sp) >>> 1;
      if (ca > hi || ca < lo || cb > hi || cb < lo) c.saturated = 1'b1;
      ca = (ca > hi) ? hi : (ca < lo) ? lo : ca;
      cb = (cb > hi) ? hi : (cb < lo) ? lo : cb;
    end
    c.child_a           = ca[GW-1:0];
    c.child_b           = cb[GW-1:0];
    c.end_of_individual = p.last_gene;
    c.end_of_batch      = p.last_pair;
    return c;
  endfunction

  // -------------------------------------------------------------------- clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // ------------------------------------------------------------------- driver
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // Predict each accepted transaction
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_children.push_back(cross_genes(cur_genes));
        genes_in++;
      end
      // Advance to the next item, or hold the current one
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_genes.size() > 0) begin
          cur_genes = pending_genes.pop_front();
          s_axis_tdata_i  <= {cur_genes.gene_draw, cur_genes.pair_draw,
                              cur_genes.gene_b, cur_genes.gene_a};
          s_axis_tlast_i  <= cur_genes.last_gene;
          s_axis_tuser_i  <= cur_genes.last_pair;
          s_axis_tvalid_i <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------ monitor
  int unsigned stall_pct  = 0;
  int unsigned stall_cyc  = 0;
  int unsigned hold_cnt   = 0;
  bit          hold_done  = 1'b0;

  always @(posedge clk_i) begin
    child_genes_t exp_c;
    if (rst_ni) begin
      // Check each output transaction against the oldest expectation
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        genes_out++;
        if (expected_children.size() == 0) begin
          $error("unexpected output transaction: child_a %h child_b %h",
                 m_axis_tdata_o[31:0], m_axis_tdata_o[63:32]);
          errors++;
        end else begin
          exp_c = expected_children.pop_front();
          if (exp_c.saturated) sat_seen++;
          if (m_axis_tdata_o[31:0] !== exp_c.child_a) begin
            $error("child_a: expected %h, got %h", exp_c.child_a, m_axis_tdata_o[31:0]);
            errors++;
          end
          if (m_axis_tdata_o[63:32] !== exp_c.child_b) begin
            $error("child_b: expected %h, got %h", exp_c.child_b, m_axis_tdata_o[63:32]);
            errors++;
          end
          if (m_axis_tlast_o !== exp_c.end_of_individual) begin
            $error("end_of_individual: expected %b, got %b",
                   exp_c.end_of_individual, m_axis_tlast_o);
            errors++;
          end
          if (m_axis_tuser_o[0] !== exp_c.end_of_batch) begin
            $error("end_of_batch: expected %b, got %b", exp_c.end_of_batch, m_axis_tuser_o[0]);
            errors++;
          end
          if (m_axis_tuser_o[1] !== exp_c.saturated) begin
            $error("saturated: expected %b, got %b", exp_c.saturated, m_axis_tuser_o[1]);
            errors++;
          end
        end
      end
      // Hold off once for a long stretch so the pipeline backs up
      if (!hold_done && genes_out >= 600) begin
        hold_done = 1'b1;
        hold_cnt  = HOLD_CYC;
      end
      // Pick a new stall density when the current stretch runs out
      if (stall_cyc == 0) begin
        stall_cyc = $urandom_range(100, 400);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      stall_cyc--;
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // ----------------------------------------------------------------- watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cyc = 0;
      end else begin
        idle_cyc++;
      end
      if (idle_cyc >= IDLE_LIM) begin
        $display("simulated_binary_crossover_unit regression: fail");
        $finish;
      end
    end
  end

  // ----------------------------------------------------------------- stimulus
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PROB_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_PROB) cross_prob = val;
    else dist_index = val[NC_W-1:0];
  endtask

  task automatic drain_and_settle();
    do @(posedge clk_i);
    while (pending_genes.size() > 0 || s_axis_tvalid_i || expected_children.size() > 0);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  function automatic logic [GW-1:0] pick_gene();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 255) - 128;
      3: return {{8{$urandom_range(0, 1) ? 1'b1 : 1'b0}}, 24'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DW-1:0] pick_draw();
    case ($urandom_range(0, 11))
      0: return 16'd0;
      1: return 16'd32768;
      2: return 16'd1;
      3: return 16'd65535;
      4: return 16'd32767 + $urandom_range(0, 2);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // Queue pairs with a shared pair draw, a few genes each
  task automatic queue_batch(int unsigned n_genes);
    parent_genes_t p;
    int unsigned   left, len;
    logic [DW-1:0] pd;
    left = n_genes;
    while (left > 0) begin
      case ($urandom_range(0, 7))
        0: pd = 16'd0;
        1: pd = 16'hFFFF;
        2: pd = cross_prob[DW-1:0];
        3: pd = cross_prob[DW-1:0] - 1'b1;
        default: pd = $urandom_range(0, 65535);
      endcase
      len = $urandom_range(1, 6);
      if (len > left) len = left;
      p.last_pair = ($urandom_range(0, 3) == 0);
      for (int g = 0; g < len; g++) begin
        p.gene_a    = pick_gene();
        p.gene_b    = ($urandom_range(0, 7) == 0) ? p.gene_a : pick_gene();
        p.pair_draw = pd;
        p.gene_draw = pick_draw();
        // Mostly well-formed markers, with some noise on them
        if ($urandom_range(0, 9) == 0) begin
          p.last_gene = $urandom_range(0, 1);
        end else begin
          p.last_gene = (g == len - 1);
        end
        pending_genes.push_back(p);
      end
      left -= len;
    end
  endtask

  task automatic queue_directed();
    parent_genes_t p;
    logic [GW-1:0] ga [5] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0100_0000};
    logic [GW-1:0] gb [5] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'hFF00_0000};
    logic [DW-1:0] gd [6] = '{16'd0, 16'd32768, 16'd1, 16'd65535, 16'd32767, 16'd32769};
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 4; j++) begin
        p.gene_a    = ga[i];
        p.gene_b    = gb[i];
        p.pair_draw = (j == 3) ? 16'hFFFF : 16'd0;
        p.gene_draw = gd[(i + j) % 6];
        p.last_gene = j[0];
        p.last_pair = j[1];
        pending_genes.push_back(p);
      end
    end
    p.gene_draw = gd[5];
    p.pair_draw = 16'd0;
    p.last_gene = 1'b1;
    p.last_pair = 1'b1;
    pending_genes.push_back(p);
  endtask

  initial begin
    logic [PROB_W-1:0] probs [7] = '{17'd65536, 17'd0, 17'h1FFFF, 17'd32768,
                                     17'd65536, 17'd1, 17'd58982};
    logic [NC_W-1:0]   ncs   [7] = '{8'd0, 8'd255, 8'd255, 8'd1, 8'd255, 8'd7, 8'd2};
    longint unsigned r;
    // Build the root table of the power-of-two step
    r = floor_root(64'd1 << 61);
    for (int k = 0; k < LOG_FRAC; k++) begin
      pow2_roots[k] = r;
      r = floor_root(r << 30);
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: directed corners, then random pairs
    queue_directed();
    queue_batch(260);
    drain_and_settle();

    // Sweep the register settings, extremes included
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(REG_PROB, probs[ph]);
      write_reg(REG_NC, (ph == 6) ? {9'd0, 8'($urandom_range(0, 255))} : {9'd0, ncs[ph]});
      queue_batch((ph == 5) ? 40 : 260);
      drain_and_settle();
    end

    $display("Covered %0d gene pairs over 8 register settings; %0d outputs checked,",
             genes_in, genes_out);
    $display("%0d of them saturated, with one long output hold-off.", sat_seen);
    if (errors == 0) begin
      $display("simulated_binary_crossover_unit regression: pass");
    end else begin
      $display("simulated_binary_crossover_unit regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/sbx_pkg.sv
rtl/core/sbx_log2.sv
rtl/core/sbx_div.sv
rtl/core/sbx_exp2.sv
rtl/core/sbx_combine.sv
rtl/core/simulated_binary_crossover_unit.sv
tb/tb_simulated_binary_crossover_unit.sv
